// ----- sv/pixel_lut_with_histograms_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pixel LUT with histograms core
// Implication checks on a clock, switched off when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_LUT_WITH_HISTOGRAMS_CORE_DEFINES_SVH
`define PIXEL_LUT_WITH_HISTOGRAMS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PLH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define PLH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PLH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PLH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- sv/plh_pkg.sv -----
// ----------------------------------------------------------------------------
// plh_pkg
// Shared types and constants of the pixel LUT with histograms core.
// ----------------------------------------------------------------------------
package plh_pkg;

   localparam int PIX_W     = 8;
   localparam int REPORT_W  = 32;
   localparam int RSP_DEPTH = 4;

   typedef enum logic [1:0] {
      ACT_PIXEL     = 2'd0,
      ACT_LUT_WRITE = 2'd1,
      ACT_READ      = 2'd2
   } action_type;

   typedef struct packed {
      logic [PIX_W-1:0]    pixel_out;
      logic                pixel_out_valid;
      logic                vsync_out;
      logic [REPORT_W-1:0] hist_in_count;
      logic [REPORT_W-1:0] hist_out_count;
      logic [PIX_W-1:0]    lut_read_value;
      logic [REPORT_W-1:0] frame_pixel_count;
   } rsp_type;

endpackage

// ----- sv/plh_ifs.sv -----
// ----------------------------------------------------------------------------
// plh_req_if / plh_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface plh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       pixel_valid;
   logic       vsync;
   logic [7:0] pixel;
   logic [7:0] entry_index;
   logic [7:0] lut_write_value;

   modport source (output valid, action, pixel_valid, vsync, pixel, entry_index,
                   lut_write_value, input ready);
   modport sink   (input valid, action, pixel_valid, vsync, pixel, entry_index,
                   lut_write_value, output ready);
endinterface

interface plh_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_out;
   logic        pixel_out_valid;
   logic        vsync_out;
   logic [31:0] hist_in_count;
   logic [31:0] hist_out_count;
   logic [7:0]  lut_read_value;
   logic [31:0] frame_pixel_count;

   modport source (output valid, pixel_out, pixel_out_valid, vsync_out, hist_in_count,
                   hist_out_count, lut_read_value, frame_pixel_count, input ready);
   modport sink   (input valid, pixel_out, pixel_out_valid, vsync_out, hist_in_count,
                   hist_out_count, lut_read_value, frame_pixel_count, output ready);
endinterface

// ----- sv/plh_ram.sv -----
// ----------------------------------------------------------------------------
// plh_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/plh_store.sv -----
// ----------------------------------------------------------------------------
// plh_store
// Read-modify-write store: RAM plus per-entry valid bits and a one-deep
// write forward. Each read issues in the cycle before its matching write.
// ----------------------------------------------------------------------------
module plh_store #(
   parameter int WIDTH         = 32,
   parameter int DEPTH         = 256,
   parameter bit IDENTITY_INIT = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     clear_all,
   output logic [WIDTH-1:0]         cur_data
);

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0]    addr_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic             fwd_ok_ff, fwd_ok_in;
   logic [AW-1:0]    fwd_addr_ff, fwd_addr_in;
   logic [WIDTH-1:0] fwd_data_ff, fwd_data_in;
   logic [WIDTH-1:0] ram_q;
   logic [WIDTH-1:0] blank;

   plh_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // unwritten entries read as their reset content
   assign blank = IDENTITY_INIT ? WIDTH'(addr_ff) : '0;

   always_comb begin
      if (fwd_ok_ff && (fwd_addr_ff == addr_ff)) begin
         cur_data = fwd_data_ff;
      end else if (valid_ff[addr_ff]) begin
         cur_data = ram_q;
      end else begin
         cur_data = blank;
      end
   end

   always_comb begin
      valid_in    = valid_ff;
      fwd_ok_in   = fwd_ok_ff;
      fwd_addr_in = fwd_addr_ff;
      fwd_data_in = fwd_data_ff;
      if (clear_all) begin
         valid_in  = '0;
         fwd_ok_in = 1'b0;
      end else if (wr_en) begin
         valid_in[addr_ff] = 1'b1;
         fwd_ok_in         = 1'b1;
         fwd_addr_in       = addr_ff;
         fwd_data_in       = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         fwd_ok_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         fwd_ok_ff <= fwd_ok_in;
      end
      addr_ff     <= rd_addr;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

endmodule

// ----- sv/plh_rsp_fifo.sv -----
// ----------------------------------------------------------------------------
// plh_rsp_fifo
// Small register FIFO holding finished response beats.
// ----------------------------------------------------------------------------
module plh_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  plh_pkg::rsp_type           push_data,
   input  logic                       pop,
   output logic                       out_valid,
   output plh_pkg::rsp_type           out_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   plh_pkg::rsp_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- sv/pixel_lut_with_histograms_core.sv -----
// ----------------------------------------------------------------------------
// pixel_lut_with_histograms_core
// Maps each pixel through a LEVELS-entry table and keeps saturating
// histograms of input and output levels plus a per-frame pixel count.
// One beat is accepted per clock while req ready is high. The rate is held
// by the three read-modify-write stores (table, input histogram, output
// histogram), each a RAM with registered read data and a write forward,
// and by a 4-entry response FIFO whose free space gates req ready. No
// clearing pass runs after reset: per-entry valid bits give the table its
// identity content and the histograms zero, and a rising vsync on a pixel
// beat with statistics on clears the histograms and the frame count.
// ----------------------------------------------------------------------------
`include "pixel_lut_with_histograms_core_defines.svh"

module pixel_lut_with_histograms_core #(
   parameter int LEVELS      = 256,
   parameter int COUNT_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data,
   plh_req_if.sink       req_chan,
   plh_rsp_if.source     rsp_chan
);

   localparam int IDX_W  = $clog2(LEVELS);
   localparam int REM_W  = IDX_W + 1;
   localparam int CW     = COUNT_WIDTH;
   localparam int PW     = plh_pkg::PIX_W;
   localparam int RW     = plh_pkg::REPORT_W;
   localparam int FCNT_W = $clog2(plh_pkg::RSP_DEPTH + 1);

   function automatic logic [IDX_W-1:0] level_of(input logic [PW-1:0] v);
      logic [REM_W-1:0] rem;
      rem = '0;
      for (int i = PW - 1; i >= 0; i--) begin
         rem = {rem[REM_W-2:0], v[i]};
         if (rem >= REM_W'(LEVELS)) begin
            rem = rem - REM_W'(LEVELS);
         end
      end
      return rem[IDX_W-1:0];
   endfunction

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
      return (c == {CW{1'b1}}) ? c : c + CW'(1);
   endfunction

   function automatic logic [RW-1:0] report(input logic [CW-1:0] c);
      logic [63:0] c64;
      c64 = 64'(c);
      return (c64 > 64'h0000_0000_FFFF_FFFF) ? {RW{1'b1}} : c64[RW-1:0];
   endfunction

   // ---------------- request stage ----------------
   logic              stats_en_ff;
   logic              last_vsync_ff, last_vsync_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              req_accept;
   logic              is_pix;
   logic              edge0, inc0;
   logic [IDX_W-1:0]  pix_lvl, idx_lvl, rd_addr0;
   logic [FCNT_W:0]   pending;
   logic [FCNT_W-1:0] fifo_count;

   // first stage registers
   logic              s1_valid_ff;
   logic [1:0]        s1_action_ff;
   logic              s1_pixel_valid_ff, s1_vsync_ff, s1_inc_ff, s1_clear_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [PW-1:0]     s1_wval_ff;
   logic [RW-1:0]     s1_count_ff;

   // second stage registers
   logic              s2_valid_ff;
   logic [1:0]        s2_action_ff;
   logic              s2_pixel_valid_ff, s2_vsync_ff, s2_inc_ff, s2_clear_ff;
   logic [PW-1:0]     s2_lut_ff;
   logic [RW-1:0]     s2_hin_ff;
   logic [RW-1:0]     s2_count_ff;

   logic [PW-1:0]     lut_cur;
   logic [CW-1:0]     hin_cur, hout_cur;
   logic [IDX_W-1:0]  rd_addr1;
   plh_pkg::rsp_type  rsp_beat, rsp_head;
   logic              rsp_pop;

   assign pending        = {1'b0, fifo_count} + (FCNT_W + 1)'(s1_valid_ff)
                           + (FCNT_W + 1)'(s2_valid_ff);
   assign req_chan.ready = (pending < (FCNT_W + 1)'(plh_pkg::RSP_DEPTH));
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign pix_lvl  = level_of(req_chan.pixel);
   assign idx_lvl  = level_of(req_chan.entry_index);
   assign is_pix   = req_accept && (req_chan.action == plh_pkg::ACT_PIXEL);
   assign rd_addr0 = (req_chan.action == plh_pkg::ACT_PIXEL) ? pix_lvl : idx_lvl;
   assign edge0    = is_pix && req_chan.vsync && !last_vsync_ff && stats_en_ff;
   assign inc0     = is_pix && req_chan.pixel_valid && stats_en_ff;

   always_comb begin
      cnt_in        = inc0 ? sat_inc(cnt_ff) : cnt_ff;
      last_vsync_in = is_pix ? req_chan.vsync : last_vsync_ff;
      // count the edge pixel first, then clear
      if (edge0) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_en_ff   <= 1'b0;
         last_vsync_ff <= 1'b0;
         cnt_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            stats_en_ff <= csr_wr_data;
         end
         last_vsync_ff <= last_vsync_in;
         cnt_ff        <= cnt_in;
         s1_valid_ff   <= req_accept;
         s2_valid_ff   <= s1_valid_ff;
      end
      s1_action_ff      <= req_chan.action;
      s1_pixel_valid_ff <= req_chan.pixel_valid;
      s1_vsync_ff       <= req_chan.vsync;
      s1_inc_ff         <= inc0;
      s1_clear_ff       <= edge0;
      s1_idx_ff         <= idx_lvl;
      s1_wval_ff        <= req_chan.lut_write_value;
      s1_count_ff       <= report(cnt_in);

      s2_action_ff      <= s1_action_ff;
      s2_pixel_valid_ff <= s1_pixel_valid_ff;
      s2_vsync_ff       <= s1_vsync_ff;
      s2_inc_ff         <= s1_inc_ff;
      s2_clear_ff       <= s1_clear_ff;
      s2_lut_ff         <= lut_cur;
      s2_hin_ff         <= report(hin_cur);
      s2_count_ff       <= s1_count_ff;
   end

   // ---------------- table and input histogram (write in stage 1) ----------------
   plh_store #(
      .WIDTH         (PW),
      .DEPTH         (LEVELS),
      .IDENTITY_INIT (1'b1)
   ) u_lut (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr0),
      .wr_en     (s1_valid_ff && (s1_action_ff == plh_pkg::ACT_LUT_WRITE)),
      .wr_data   (s1_wval_ff),
      .clear_all (1'b0),
      .cur_data  (lut_cur)
   );

   plh_store #(
      .WIDTH         (CW),
      .DEPTH         (LEVELS),
      .IDENTITY_INIT (1'b0)
   ) u_hist_in (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr0),
      .wr_en     (s1_valid_ff && s1_inc_ff && !s1_clear_ff),
      .wr_data   (sat_inc(hin_cur)),
      .clear_all (s1_valid_ff && s1_clear_ff),
      .cur_data  (hin_cur)
   );

   // output bin follows the mapped value, so its read issues one stage later
   assign rd_addr1 = (s1_action_ff == plh_pkg::ACT_PIXEL) ? level_of(lut_cur) : s1_idx_ff;

   plh_store #(
      .WIDTH         (CW),
      .DEPTH         (LEVELS),
      .IDENTITY_INIT (1'b0)
   ) u_hist_out (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr1),
      .wr_en     (s2_valid_ff && s2_inc_ff && !s2_clear_ff),
      .wr_data   (sat_inc(hout_cur)),
      .clear_all (s2_valid_ff && s2_clear_ff),
      .cur_data  (hout_cur)
   );

   // ---------------- response assembly ----------------
   always_comb begin
      rsp_beat                   = '0;
      rsp_beat.vsync_out         = s2_vsync_ff;
      rsp_beat.frame_pixel_count = s2_count_ff;
      if ((s2_action_ff == plh_pkg::ACT_PIXEL) && s2_pixel_valid_ff) begin
         rsp_beat.pixel_out       = s2_lut_ff;
         rsp_beat.pixel_out_valid = 1'b1;
      end
      if (s2_action_ff == plh_pkg::ACT_READ) begin
         rsp_beat.hist_in_count  = s2_hin_ff;
         rsp_beat.hist_out_count = report(hout_cur);
         rsp_beat.lut_read_value = s2_lut_ff;
      end
   end

   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;

   plh_rsp_fifo #(
      .DEPTH (plh_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (rsp_beat),
      .pop       (rsp_pop),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_head),
      .count     (fifo_count)
   );

   assign rsp_chan.pixel_out         = rsp_head.pixel_out;
   assign rsp_chan.pixel_out_valid   = rsp_head.pixel_out_valid;
   assign rsp_chan.vsync_out         = rsp_head.vsync_out;
   assign rsp_chan.hist_in_count     = rsp_head.hist_in_count;
   assign rsp_chan.hist_out_count    = rsp_head.hist_out_count;
   assign rsp_chan.lut_read_value    = rsp_head.lut_read_value;
   assign rsp_chan.frame_pixel_count = rsp_head.frame_pixel_count;

   // ---------------- assertions ----------------
   `PLH_ASSERT_IMP(a_push_has_room, clock, reset, s2_valid_ff, fifo_count < FCNT_W'(plh_pkg::RSP_DEPTH), "response beat pushed into full FIFO")
   `PLH_ASSERT_NXT(a_edge_clears_count, clock, reset, req_accept && edge0, cnt_ff == '0, "frame count not cleared on vsync edge")
   `PLH_ASSERT_NXT(a_count_holds_idle, clock, reset, !req_accept, cnt_ff == $past(cnt_ff), "frame count moved without a beat")

endmodule

// ----- tb/pixel_lut_with_histograms_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_lut_with_histograms_core_test
// Self-checking bench for the pixel LUT with histograms core. A directed
// table walks reset contents, extremes, table writes, reads, the unused
// action code and vsync edges with statistics off and on. Random framed
// pixel streams mixed with writes, reads and noise follow. Every request
// beat is run through a local predictor and each response beat is compared
// field by field, under sender gaps, receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module pixel_lut_with_histograms_core_test;
   import plh_pkg::*;

   localparam int          CNT_W      = 32;
   localparam int          CYCLE_CAP  = 400000;
   localparam int          HOLD_LEN   = 300;
   localparam int          TAIL_WAIT  = 20;
   localparam logic [1:0]  ACT_SPARE  = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic       pixel_valid;
      logic       vsync;
      logic [7:0] pixel;
      logic [7:0] entry_index;
      logic [7:0] lut_write_value;
   } beat_t;

   typedef struct {
      bit      stats;
      bit      typed;
      beat_t   beat;
      rsp_type want;
   } dir_row_t;

   typedef struct {
      bit      typed;
      rsp_type want;
   } hint_t;

   typedef struct {
      bit stats;
      int idle;
      int stall;
      int count;
      bit hold;
      bit pause;
   } phase_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   plh_req_if req_chan ();
   plh_rsp_if rsp_chan ();

   pixel_lut_with_histograms_core DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the block state
   logic [7:0]       lut_mem  [256];
   logic [CNT_W-1:0] in_bins  [256];
   logic [CNT_W-1:0] out_bins [256];
   logic [CNT_W-1:0] frame_count = '0;
   logic             prev_vsync  = 1'b0;
   bit               stats_on    = 1'b0;

   rsp_type  rsp_expected_q [$];
   hint_t    hint_q [$];
   dir_row_t dir_tab [$];

   int idle_pct  = 0;
   int stall_pct = 0;
   bit hold_go   = 1'b0;
   int hold_left = -1;
   int errors    = 0;
   int checked   = 0;
   int clears    = 0;
   int cycles    = 0;
   int tally [4] = '{0, 0, 0, 0};

   // stream shaping
   int         frame_left = 0;
   int         sync_left  = 0;
   logic [7:0] last_level = 8'h00;

   phase_t plan [7] = '{
      '{1'b1,  0,  0, 300, 1'b1, 1'b0},
      '{1'b1, 74,  0, 250, 1'b0, 1'b0},
      '{1'b0,  0, 74, 250, 1'b0, 1'b0},
      '{1'b1, 24, 24, 300, 1'b0, 1'b1},
      '{1'b0, 24, 24, 150, 1'b0, 1'b0},
      '{1'b1,  0,  0, 300, 1'b0, 1'b1},
      '{1'b1,  0, 74, 250, 1'b0, 1'b0}
   };

   initial begin
      for (int i = 0; i < 256; i++) begin
         lut_mem[i]  = i[7:0];
         in_bins[i]  = '0;
         out_bins[i] = '0;
      end
   end

   function automatic logic [31:0] clip32(logic [63:0] c);
      return (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
   endfunction

   function automatic rsp_type map_and_count(beat_t b);
      rsp_type    r;
      logic [7:0] y;
      r = '0;
      r.vsync_out = b.vsync;
      tally[b.action]++;
      case (b.action)
         ACT_PIXEL: begin
            if (b.pixel_valid) begin
               y = lut_mem[b.pixel];
               r.pixel_out       = y;
               r.pixel_out_valid = 1'b1;
               if (stats_on) begin
                  in_bins[b.pixel] += (in_bins[b.pixel] != '1);
                  out_bins[y]      += (out_bins[y] != '1);
                  frame_count      += (frame_count != '1);
               end
            end
            // count first, then clear on the rising edge
            if (b.vsync && !prev_vsync && stats_on) begin
               for (int i = 0; i < 256; i++) begin
                  in_bins[i]  = '0;
                  out_bins[i] = '0;
               end
               frame_count = '0;
               clears++;
            end
            prev_vsync = b.vsync;
         end
         ACT_LUT_WRITE: lut_mem[b.entry_index] = b.lut_write_value;
         ACT_READ: begin
            r.hist_in_count  = clip32(64'(in_bins[b.entry_index]));
            r.hist_out_count = clip32(64'(out_bins[b.entry_index]));
            r.lut_read_value = lut_mem[b.entry_index];
         end
         default: ;
      endcase
      r.frame_pixel_count = clip32(64'(frame_count));
      return r;
   endfunction

   function automatic beat_t mk_beat(logic [1:0] act, bit pv, bit vs, logic [7:0] pix,
                                     logic [7:0] idx, logic [7:0] wv);
      beat_t b;
      b.action          = act;
      b.pixel_valid     = pv;
      b.vsync           = vs;
      b.pixel           = pix;
      b.entry_index     = idx;
      b.lut_write_value = wv;
      return b;
   endfunction

   function automatic rsp_type mk_rsp(logic [7:0] pix, bit pov, bit vs, logic [31:0] hin,
                                      logic [31:0] hout, logic [7:0] lut,
                                      logic [31:0] frame);
      rsp_type r;
      r.pixel_out         = pix;
      r.pixel_out_valid   = pov;
      r.vsync_out         = vs;
      r.hist_in_count     = hin;
      r.hist_out_count    = hout;
      r.lut_read_value    = lut;
      r.frame_pixel_count = frame;
      return r;
   endfunction

   function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (got === want)
         return 0;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
   endfunction

   // mostly framed pixel runs, with writes, reads and some noise
   function automatic beat_t next_stream_beat();
      beat_t b;
      int    pick;
      b.action          = ACT_PIXEL;
      b.pixel_valid     = $urandom_range(1);
      b.vsync           = $urandom_range(1);
      b.pixel           = $urandom_range(255);
      b.entry_index     = $urandom_range(255);
      b.lut_write_value = $urandom_range(255);
      pick = $urandom_range(99);
      if (pick < 72) begin
         b.pixel_valid = ($urandom_range(99) < 85);
         if ($urandom_range(99) < 30)
            b.pixel = $urandom_range(15);
         else if ($urandom_range(99) < 5)
            b.pixel = $urandom_range(1) ? 8'hFF : 8'h00;
         if ($urandom_range(99) >= 5) begin
            if (sync_left > 0) begin
               b.vsync = 1'b1;
               sync_left--;
            end else begin
               b.vsync = 1'b0;
               if (frame_left == 0) begin
                  sync_left  = $urandom_range(1, 3);
                  frame_left = $urandom_range(4, 60);
               end else begin
                  frame_left--;
               end
            end
         end
         if (b.pixel_valid)
            last_level = b.pixel;
      end else if (pick < 82) begin
         b.action = ACT_LUT_WRITE;
         if ($urandom_range(99) < 10)
            b.lut_write_value = $urandom_range(1) ? 8'hFF : 8'h00;
      end else if (pick < 96) begin
         b.action = ACT_READ;
         case ($urandom_range(3))
            0: b.entry_index = last_level;
            1: b.entry_index = lut_mem[last_level];
            2: b.entry_index = $urandom_range(15);
            default: ;
         endcase
      end else begin
         b.action = ACT_SPARE;
      end
      return b;
   endfunction

   task automatic offer(beat_t b, bit typed, rsp_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.action          <= b.action;
      req_chan.pixel_valid     <= b.pixel_valid;
      req_chan.vsync           <= b.vsync;
      req_chan.pixel           <= b.pixel;
      req_chan.entry_index     <= b.entry_index;
      req_chan.lut_write_value <= b.lut_write_value;
      hint_q.push_back('{typed, want});
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (rsp_expected_q.size() != 0);
   endtask

   task automatic set_stats(bit on);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      stats_on  = on;
      csr_wr_en <= 1'b0;
   endtask

   // request side: predict at the accepting edge
   always @(posedge clock) begin
      beat_t   b;
      hint_t   h;
      rsp_type p;
      if (!reset && req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
         b.action          = req_chan.action;
         b.pixel_valid     = req_chan.pixel_valid;
         b.vsync           = req_chan.vsync;
         b.pixel           = req_chan.pixel;
         b.entry_index     = req_chan.entry_index;
         b.lut_write_value = req_chan.lut_write_value;
         h = hint_q.pop_front();
         p = map_and_count(b);
         rsp_expected_q.push_back(h.typed ? h.want : p);
      end
   end

   // response side: hold off for a long stretch once, otherwise stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_go && hold_left != 0) begin
         if (hold_left < 0)
            hold_left = HOLD_LEN;
         else
            hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.pixel_out         = rsp_chan.pixel_out;
         got.pixel_out_valid   = rsp_chan.pixel_out_valid;
         got.vsync_out         = rsp_chan.vsync_out;
         got.hist_in_count     = rsp_chan.hist_in_count;
         got.hist_out_count    = rsp_chan.hist_out_count;
         got.lut_read_value    = rsp_chan.lut_read_value;
         got.frame_pixel_count = rsp_chan.frame_pixel_count;
         if (rsp_expected_q.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            want = rsp_expected_q.pop_front();
            errors += field_diff("pixel_out", 32'(want.pixel_out), 32'(got.pixel_out));
            errors += field_diff("pixel_out_valid", 32'(want.pixel_out_valid),
                                 32'(got.pixel_out_valid));
            errors += field_diff("vsync_out", 32'(want.vsync_out), 32'(got.vsync_out));
            errors += field_diff("hist_in_count", want.hist_in_count, got.hist_in_count);
            errors += field_diff("hist_out_count", want.hist_out_count, got.hist_out_count);
            errors += field_diff("lut_read_value", 32'(want.lut_read_value),
                                 32'(got.lut_read_value));
            errors += field_diff("frame_pixel_count", want.frame_pixel_count,
                                 got.frame_pixel_count);
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  rsp_expected_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset                    <= 1'b1;
      csr_wr_en                <= 1'b0;
      csr_wr_data              <= 1'b0;
      req_chan.valid           <= 1'b0;
      req_chan.action          <= ACT_PIXEL;
      req_chan.pixel_valid     <= 1'b0;
      req_chan.vsync           <= 1'b0;
      req_chan.pixel           <= 8'h00;
      req_chan.entry_index     <= 8'h00;
      req_chan.lut_write_value <= 8'h00;

      // reset contents and extremes, statistics off
      dir_tab.push_back('{0, 1, mk_beat(ACT_READ, 0, 0, 8'h00, 8'h00, 8'h00),
                              mk_rsp(8'h00, 0, 0, 0, 0, 8'h00, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_READ, 0, 0, 8'h00, 8'hFF, 8'h00),
                              mk_rsp(8'h00, 0, 0, 0, 0, 8'hFF, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_PIXEL, 1, 0, 8'h00, 8'h00, 8'h00),
                              mk_rsp(8'h00, 1, 0, 0, 0, 8'h00, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_PIXEL, 1, 0, 8'hFF, 8'h00, 8'h00),
                              mk_rsp(8'hFF, 1, 0, 0, 0, 8'h00, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_PIXEL, 0, 1, 8'hAA, 8'h00, 8'h00),
                              mk_rsp(8'h00, 0, 1, 0, 0, 8'h00, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_SPARE, 1, 1, 8'hFF, 8'hFF, 8'hFF),
                              mk_rsp(8'h00, 0, 1, 0, 0, 8'h00, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_LUT_WRITE, 0, 0, 8'h00, 8'h00, 8'hFF),
                              mk_rsp(8'h00, 0, 0, 0, 0, 8'h00, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_LUT_WRITE, 0, 0, 8'h00, 8'hFF, 8'h00),
                              mk_rsp(8'h00, 0, 0, 0, 0, 8'h00, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_PIXEL, 1, 0, 8'h00, 8'h00, 8'h00),
                              mk_rsp(8'hFF, 1, 0, 0, 0, 8'h00, 0)});
      dir_tab.push_back('{0, 1, mk_beat(ACT_READ, 0, 0, 8'h00, 8'h00, 8'h00),
                              mk_rsp(8'h00, 0, 0, 0, 0, 8'hFF, 0)});
      // statistics on: counting, vsync edges, reads and writes leave the edge alone
      dir_tab.push_back('{1, 0, mk_beat(ACT_PIXEL, 1, 0, 8'h00, 8'h00, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_PIXEL, 1, 0, 8'h55, 8'h00, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_READ, 0, 0, 8'h00, 8'h00, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_READ, 1, 0, 8'h00, 8'hFF, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_LUT_WRITE, 1, 1, 8'h00, 8'h5A, 8'hA5), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_PIXEL, 1, 1, 8'h5A, 8'h00, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_READ, 0, 0, 8'h00, 8'h5A, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_PIXEL, 1, 1, 8'hFF, 8'h00, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_PIXEL, 0, 0, 8'h00, 8'h00, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_READ, 0, 1, 8'h00, 8'h00, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_PIXEL, 0, 1, 8'h00, 8'h00, 8'h00), '0});
      dir_tab.push_back('{1, 0, mk_beat(ACT_SPARE, 0, 0, 8'h00, 8'h00, 8'h00), '0});
      // statistics off again: an edge must not clear
      dir_tab.push_back('{0, 0, mk_beat(ACT_PIXEL, 1, 0, 8'h03, 8'h00, 8'h00), '0});
      dir_tab.push_back('{0, 0, mk_beat(ACT_PIXEL, 1, 1, 8'h03, 8'h00, 8'h00), '0});
      dir_tab.push_back('{0, 0, mk_beat(ACT_READ, 0, 0, 8'h00, 8'h03, 8'h00), '0});

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].stats != stats_on)
            set_stats(dir_tab[i].stats);
         offer(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
      end

      foreach (plan[p]) begin
         if (plan[p].stats != stats_on)
            set_stats(plan[p].stats);
         idle_pct  = plan[p].idle;
         stall_pct = plan[p].stall;
         // sender keeps offering while the response side is held off
         if (plan[p].hold)
            hold_go = 1'b1;
         for (int n = 0; n < plan[p].count; n++) begin
            if (plan[p].pause && n == plan[p].count / 2)
               drain();
            offer(next_stream_beat(), 1'b0, '0);
         end
      end

      drain();
      repeat (TAIL_WAIT) @(posedge clock);
      if (rsp_expected_q.size() != 0) begin
         $error("%0d expected results never arrived", rsp_expected_q.size());
         errors++;
      end

      $display("covered %0d pixel ticks, %0d table writes, %0d reads, %0d unused-code beats",
               tally[ACT_PIXEL], tally[ACT_LUT_WRITE], tally[ACT_READ], tally[ACT_SPARE]);
      $display("%0d frame clears, %0d responses checked, %0d field mismatches",
               clears, checked, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
